// ----- rtl/core/pressure_sensor_compensation_assert.svh -----
// Assertion macros for the pressure sensor compensation block.
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define PSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/psc_pkg.sv -----
// Package: types and constants of the pressure sensor compensation block.
`default_nettype none
package psc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int COEF_W      = 16;
   localparam int TEMP_REF    = 2000;
   localparam int TEMP_DEEP   = 1500;
   localparam int PIPE_DEPTH  = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SENS        = 3'd0,
      CSR_OFFSET      = 3'd1,
      CSR_SENS_TEMP   = 3'd2,
      CSR_OFFSET_TEMP = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [19:0] temperature_centi;
      logic signed [31:0] pressure_deci;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens;
      logic [COEF_W-1:0] offset;
      logic [COEF_W-1:0] sens_temp;
      logic [COEF_W-1:0] offset_temp;
      logic [COEF_W-1:0] ref_temp;
      logic [COEF_W-1:0] temp_slope;
   } coef_type;

   // first-order results
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [18:0] tm20;
      logic signed [18:0] tp15;
      logic signed [35:0] off;
      logic signed [35:0] sens;
      logic [17:0]        ti;
   } front_type;

   // second-order corrected terms
   typedef struct packed {
      logic [23:0]        raw_pressure;
      logic signed [19:0] temperature_centi;
      logic signed [38:0] sens_diff;
      logic signed [38:0] off_diff;
   } back_type;

endpackage
`default_nettype wire

// ----- rtl/core/psc_first.sv -----
// First-order stages: dT, calibration products, offset, sensitivity, Ti.
`default_nettype none
module psc_first (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire psc_pkg::req_type   in_data,
   input  wire psc_pkg::coef_type  coef,
   output logic                    out_valid,
   output psc_pkg::front_type      out_data
);

   // stage 1: dT
   logic               s1_valid_ff;
   logic [23:0]        s1_press_ff;
   logic signed [24:0] s1_dt_ff;
   logic signed [24:0] s1_dt_in;

   // stage 2: products
   logic               s2_valid_ff;
   logic [23:0]        s2_press_ff;
   logic signed [41:0] s2_ptemp_ff, s2_ptemp_in;
   logic signed [41:0] s2_poff_ff, s2_poff_in;
   logic signed [41:0] s2_psens_ff, s2_psens_in;
   logic signed [49:0] s2_dtsq_ff, s2_dtsq_in;

   // stage 3: first-order terms
   logic               s3_valid_ff;
   psc_pkg::front_type s3_ff, s3_in;
   logic [51:0]        dtsq3;

   always_comb begin
      s1_dt_in = $signed({1'b0, in_data.raw_temperature})
               - $signed({1'b0, coef.ref_temp, 8'b0});
   end

   always_comb begin
      s2_ptemp_in = s1_dt_ff * $signed({1'b0, coef.temp_slope});
      s2_poff_in  = s1_dt_ff * $signed({1'b0, coef.offset_temp});
      s2_psens_in = s1_dt_ff * $signed({1'b0, coef.sens_temp});
      s2_dtsq_in  = s1_dt_ff * s1_dt_ff;
   end

   always_comb begin
      dtsq3 = {2'b0, s2_dtsq_ff} + {1'b0, s2_dtsq_ff, 1'b0};
      s3_in.raw_pressure = s2_press_ff;
      s3_in.tm20 = $signed(s2_ptemp_ff[41:23]);
      s3_in.tp15 = $signed(s2_ptemp_ff[41:23])
                 + 19'(psc_pkg::TEMP_REF + psc_pkg::TEMP_DEEP);
      s3_in.off  = $signed({4'b0, coef.offset, 16'b0}) + 36'(s2_poff_ff >>> 7);
      s3_in.sens = $signed({5'b0, coef.sens, 15'b0}) + 36'(s2_psens_ff >>> 8);
      // below 20 degC: 3*dT^2 >> 33, else 2*dT^2 >> 37
      if (s2_ptemp_ff[41]) begin
         s3_in.ti = dtsq3[50:33];
      end else begin
         s3_in.ti = {4'b0, s2_dtsq_ff[49:36]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_press_ff <= in_data.raw_pressure;
         s1_dt_ff    <= s1_dt_in;
      end
      if (s1_valid_ff) begin
         s2_press_ff <= s1_press_ff;
         s2_ptemp_ff <= s2_ptemp_in;
         s2_poff_ff  <= s2_poff_in;
         s2_psens_ff <= s2_psens_in;
         s2_dtsq_ff  <= s2_dtsq_in;
      end
      if (s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule
`default_nettype wire

// ----- rtl/core/psc_second.sv -----
// Second-order stages: band squares, OFFi and SENSi, corrected terms, temperature.
`default_nettype none
module psc_second (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire psc_pkg::front_type  in_data,
   output logic                     out_valid,
   output psc_pkg::back_type        out_data
);

   // stage 4: squares and temperature
   logic               s4_valid_ff;
   logic [23:0]        s4_press_ff;
   logic signed [35:0] s4_off_ff, s4_sens_ff;
   logic [35:0]        s4_sqm_ff, s4_sqp_ff;
   logic signed [37:0] sqm_full, sqp_full;
   logic               s4_cold_ff, s4_deep_ff;
   logic signed [20:0] tsum;
   logic signed [19:0] s4_temp_ff, s4_temp_in;

   // stage 5: corrections
   logic               s5_valid_ff;
   logic [23:0]        s5_press_ff;
   logic signed [35:0] s5_off_ff, s5_sens_ff;
   logic signed [19:0] s5_temp_ff;
   logic [37:0]        s5_offi_ff, s5_offi_in;
   logic [37:0]        s5_sensi_ff, s5_sensi_in;
   logic [37:0]        m3, m5, p7, p4;

   // stage 6: corrected sensitivity and offset
   logic               s6_valid_ff;
   psc_pkg::back_type  s6_ff, s6_in;

   always_comb begin
      sqm_full = in_data.tm20 * in_data.tm20;
      sqp_full = in_data.tp15 * in_data.tp15;
      tsum = 21'(in_data.tm20) + 21'(psc_pkg::TEMP_REF) - $signed({3'b0, in_data.ti});
      if (tsum[20] != tsum[19]) begin
         s4_temp_in = tsum[20] ? $signed({1'b1, 19'b0}) : $signed({1'b0, {19{1'b1}}});
      end else begin
         s4_temp_in = tsum[19:0];
      end
   end

   always_comb begin
      m3 = {2'b0, s4_sqm_ff} + {1'b0, s4_sqm_ff, 1'b0};
      m5 = {2'b0, s4_sqm_ff} + {s4_sqm_ff, 2'b0};
      p7 = 38'({s4_sqp_ff, 3'b0} - {3'b0, s4_sqp_ff});
      p4 = {s4_sqp_ff, 2'b0};
      if (s4_cold_ff) begin
         s5_offi_in  = {1'b0, m3[37:1]} + (s4_deep_ff ? p7 : '0);
         s5_sensi_in = {3'b0, m5[37:3]} + (s4_deep_ff ? p4 : '0);
      end else begin
         s5_offi_in  = {6'b0, s4_sqm_ff[35:4]};
         s5_sensi_in = '0;
      end
   end

   always_comb begin
      s6_in.raw_pressure      = s5_press_ff;
      s6_in.temperature_centi = s5_temp_ff;
      s6_in.sens_diff         = 39'(s5_sens_ff) - $signed({1'b0, s5_sensi_ff});
      s6_in.off_diff          = 39'(s5_off_ff) - $signed({1'b0, s5_offi_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_valid;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s4_press_ff <= in_data.raw_pressure;
         s4_off_ff   <= in_data.off;
         s4_sens_ff  <= in_data.sens;
         s4_sqm_ff   <= sqm_full[35:0];
         s4_sqp_ff   <= sqp_full[35:0];
         s4_cold_ff  <= in_data.tm20[18];
         s4_deep_ff  <= in_data.tp15[18];
         s4_temp_ff  <= s4_temp_in;
      end
      if (s4_valid_ff) begin
         s5_press_ff <= s4_press_ff;
         s5_off_ff   <= s4_off_ff;
         s5_sens_ff  <= s4_sens_ff;
         s5_temp_ff  <= s4_temp_ff;
         s5_offi_ff  <= s5_offi_in;
         s5_sensi_ff <= s5_sensi_in;
      end
      if (s5_valid_ff) begin
         s6_ff <= s6_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_data  = s6_ff;

endmodule
`default_nettype wire

// ----- rtl/core/psc_press.sv -----
// Pressure stages: split D1 product, scaling and the result register.
`default_nettype none
module psc_press (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire psc_pkg::back_type  in_data,
   output logic                    out_valid,
   output psc_pkg::rsp_type        out_data
);

   // stage 7: partial products
   logic               s7_valid_ff;
   logic [43:0]        s7_pplo_ff, s7_pplo_in;
   logic signed [43:0] s7_pphi_ff, s7_pphi_in;
   logic signed [38:0] s7_od_ff;
   logic signed [19:0] s7_temp_ff;

   // stage 8: full product
   logic               s8_valid_ff;
   logic signed [63:0] s8_prod_ff, s8_prod_in;
   logic signed [38:0] s8_od_ff;
   logic signed [19:0] s8_temp_ff;

   // stage 9: result
   logic               s9_valid_ff;
   psc_pkg::rsp_type   s9_ff, s9_in;
   logic signed [43:0] diff;

   always_comb begin
      s7_pplo_in = in_data.raw_pressure * in_data.sens_diff[19:0];
      s7_pphi_in = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sens_diff[38:20]);
   end

   always_comb begin
      s8_prod_in = (64'(s7_pphi_ff) <<< 20) + $signed({20'b0, s7_pplo_ff});
   end

   // the scaled value always fits the 32-bit field
   always_comb begin
      diff = 44'(s8_prod_ff >>> 21) - 44'(s8_od_ff);
      s9_in.temperature_centi = s8_temp_ff;
      s9_in.pressure_deci     = 32'(diff >>> 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= in_valid;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s7_pplo_ff <= s7_pplo_in;
         s7_pphi_ff <= s7_pphi_in;
         s7_od_ff   <= in_data.off_diff;
         s7_temp_ff <= in_data.temperature_centi;
      end
      if (s7_valid_ff) begin
         s8_prod_ff <= s8_prod_in;
         s8_od_ff   <= s7_od_ff;
         s8_temp_ff <= s7_temp_ff;
      end
      if (s8_valid_ff) begin
         s9_ff <= s9_in;
      end
   end

   assign out_valid = s9_valid_ff;
   assign out_data  = s9_ff;

endmodule
`default_nettype wire

// ----- rtl/core/pressure_sensor_compensation.sv -----
// Top level: coefficient registers and the nine-stage compensation pipeline.
//
//   channel   ports                                     handshake
//   request   start, busy, req_data                     start && !busy
//   result    rsp_valid, rsp_data                       one-cycle strobe
//   csr       csr_valid, csr_ready, csr_index, csr_data valid && ready
//
// One request per cycle while busy is low. The pipeline depth is set by
// the multiplier chain: three calibration products and dT squared, the band
// squares and the 24x39 D1 product split in two partial products.
// busy is high only during reset; synchronous reset clears the pipeline
// valid bits and the coefficients. The receiver cannot stall the pipeline.
`default_nettype none
`include "pressure_sensor_compensation_assert.svh"
module pressure_sensor_compensation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire psc_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   output psc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [psc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [psc_pkg::COEF_W-1:0]        csr_data
);

   psc_pkg::coef_type  coef_ff, coef_in;
   logic               accept;
   logic               front_valid, back_valid;
   psc_pkg::front_type front_data;
   psc_pkg::back_type  back_data;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            psc_pkg::CSR_SENS:        coef_in.sens        = csr_data;
            psc_pkg::CSR_OFFSET:      coef_in.offset      = csr_data;
            psc_pkg::CSR_SENS_TEMP:   coef_in.sens_temp   = csr_data;
            psc_pkg::CSR_OFFSET_TEMP: coef_in.offset_temp = csr_data;
            psc_pkg::CSR_REF_TEMP:    coef_in.ref_temp    = csr_data;
            psc_pkg::CSR_TEMP_SLOPE:  coef_in.temp_slope  = csr_data;
            default:                  coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   psc_first u_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .coef      (coef_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   psc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   psc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_data   (back_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   `PSC_ASSERT_IMP(a_rsp_follows_req, clock, reset, accept, ##(psc_pkg::PIPE_DEPTH) rsp_valid, "request lost in pipeline")
   `PSC_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, psc_pkg::PIPE_DEPTH), "result without request")
   `PSC_ASSERT_NXT(a_csr_unmapped, clock, reset, csr_valid && csr_ready && (csr_index > 3'(psc_pkg::CSR_TEMP_SLOPE)), $stable(coef_ff), "unmapped csr write changed a coefficient")

endmodule
`default_nettype wire
